/* rtl/per_type_window_byte_budget_core_defines.svh */
// Assertion helpers shared by the budget core.
`ifndef PER_TYPE_WINDOW_BYTE_BUDGET_CORE_DEFINES_SVH
`define PER_TYPE_WINDOW_BYTE_BUDGET_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PTWBB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ptwbb check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PTWBB_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ptwbb check failed");

`endif

/* rtl/ptwbb_pkg.sv */
package ptwbb_pkg;

    // Field widths
    localparam int TYPE_W   = 17;
    localparam int TIME_W   = 32;
    localparam int LEN_W    = 32;
    localparam int CNT_W    = 32;
    localparam int BUDGET_W = 16;
    localparam int EPOCH_W  = 32;
    localparam int USED_W   = 16;
    localparam int NEED_W   = LEN_W + 1;

    // Per-type table
    localparam int TYPE_SLOTS   = 131072;
    localparam int ADDR_W       = $clog2(TYPE_SLOTS);
    localparam int HEADER_BYTES = 12;

    // Configuration port
    localparam int REG_IDX_W  = 1;
    localparam int REG_DATA_W = 17;

    localparam logic [REG_IDX_W-1:0] REG_BUFFER_BUDGET = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_MAX_TYPE      = 1'd1;

    localparam logic [BUDGET_W-1:0] BUDGET_RESET   = 16'd2048;
    localparam logic [TYPE_W-1:0]   MAX_TYPE_RESET = 17'd100000;

    typedef struct packed {
        logic [EPOCH_W-1:0] epoch;
        logic [USED_W-1:0]  used;
        logic [CNT_W-1:0]   count;
    } t_entry;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EVAL
    } t_state;

    // Increment that stops at all ones
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (&v) ? v : v + CNT_W'(1);
    endfunction

endpackage

/* rtl/ptwbb_msg_if.sv */
interface ptwbb_msg_if;
    logic                           valid;
    logic                           ready;
    logic [ptwbb_pkg::TYPE_W-1:0]   msg_type;
    logic [ptwbb_pkg::TIME_W-1:0]   msg_time;
    logic [ptwbb_pkg::LEN_W-1:0]    msg_len;

    modport source (output valid, msg_type, msg_time, msg_len, input ready);
    modport sink   (input valid, msg_type, msg_time, msg_len, output ready);
endinterface

/* rtl/ptwbb_res_if.sv */
interface ptwbb_res_if;
    logic                           valid;
    logic                           ready;
    logic                           accepted;
    logic                           type_counted;
    logic [ptwbb_pkg::CNT_W-1:0]    type_total;
    logic [ptwbb_pkg::CNT_W-1:0]    all_messages;

    modport source (output valid, accepted, type_counted, type_total, all_messages,
                    input ready);
    modport sink   (input valid, accepted, type_counted, type_total, all_messages,
                    output ready);
endinterface

/* rtl/ptwbb_cfg_if.sv */
interface ptwbb_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [ptwbb_pkg::REG_IDX_W-1:0]    idx;
    logic [ptwbb_pkg::REG_DATA_W-1:0]   data;

    modport source (output valid, idx, data, input ready);
    modport sink   (input valid, idx, data, output ready);
endinterface

/* rtl/per_type_window_byte_budget_core.sv */
// Channel  | Dir | Beat contents
// ---------+-----+-----------------------------------------------------
// i_msg    | in  | msg_type, msg_time, msg_len (one message header)
// o_res    | out | accepted, type_counted, type_total, all_messages
// i_cfg    | in  | idx (0 buffer_budget, 1 max_type), data; always ready
//
// One header per cycle sustained while results drain; each header is
// registered and evaluated into the o_res register. The per-type table is one
// 131072-entry synchronous memory: read on acceptance, evaluated and written
// back in the next stage, with a bypass register when the next header hits
// the same type. After reset a clearing pass writes every table entry with
// i_msg.ready low. A stalled o_res holds the evaluation stage and i_msg.ready.
module per_type_window_byte_budget_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ptwbb_msg_if.sink     i_msg,
    ptwbb_res_if.source   o_res,
    ptwbb_cfg_if.sink     i_cfg
);
    import ptwbb_pkg::*;

    `include "per_type_window_byte_budget_core_defines.svh"

    t_state r_state, n_state;

    logic [BUDGET_W-1:0] r_budget;
    logic [TYPE_W-1:0]   r_max_type;
    logic [TIME_W-1:0]   r_stamp;
    logic [EPOCH_W-1:0]  r_epoch;
    logic [CNT_W-1:0]    r_msg_count;
    logic [ADDR_W-1:0]   r_clr_addr;

    logic [TYPE_W-1:0]   r_type;
    logic [TIME_W-1:0]   r_time;
    logic [LEN_W-1:0]    r_len;

    t_entry              r_mem [TYPE_SLOTS];
    t_entry              r_rd_data;
    t_entry              r_fwd_data;
    logic                r_fwd_hit;

    logic                r_out_valid;
    logic                r_out_acc;
    logic                r_out_counted;
    logic [CNT_W-1:0]    r_out_total;
    logic [CNT_W-1:0]    r_out_all;

    logic                w_clr_active;
    logic                w_clr_last;
    logic                w_out_free;
    logic                w_eval_go;
    logic                w_in_acc;

    t_entry              w_entry;
    t_entry              w_new_entry;
    logic                w_counted;
    logic                w_new_win;
    logic [EPOCH_W-1:0]  w_epoch_cur;
    logic [USED_W-1:0]   w_used;
    logic [NEED_W-1:0]   w_need;
    logic                w_fit;

    logic                w_wr_en;
    logic [ADDR_W-1:0]   w_wr_addr;
    t_entry              w_wr_data;

    // Handshake glue
    assign w_out_free = !r_out_valid || o_res.ready;
    assign w_clr_last = &r_clr_addr;
    assign w_in_acc   = i_msg.valid && i_msg.ready;
    assign i_cfg.ready = 1'b1;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (w_clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (w_in_acc) n_state = S_EVAL;
            end
            S_EVAL: begin
                if (w_out_free) n_state = w_in_acc ? S_EVAL : S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // State outputs
    always_comb begin
        w_clr_active = 1'b0;
        w_eval_go    = 1'b0;
        i_msg.ready  = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                w_clr_active = 1'b1;
            end
            S_IDLE: begin
                i_msg.ready = 1'b1;
            end
            S_EVAL: begin
                w_eval_go   = w_out_free;
                i_msg.ready = w_out_free;
            end
            default: begin
                w_clr_active = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Evaluate the header held in the second stage
    assign w_entry     = r_fwd_hit ? r_fwd_data : r_rd_data;
    assign w_counted   = r_type <= r_max_type;
    assign w_new_win   = r_time != r_stamp;
    assign w_epoch_cur = w_new_win ? r_epoch + EPOCH_W'(1) : r_epoch;
    assign w_used      = (w_entry.epoch == w_epoch_cur) ? w_entry.used : '0;
    assign w_need      = NEED_W'(w_used) + NEED_W'(HEADER_BYTES) + NEED_W'(r_len);
    assign w_fit       = w_need <= NEED_W'(r_budget);

    always_comb begin
        w_new_entry.epoch = w_epoch_cur;
        w_new_entry.used  = w_fit ? w_need[USED_W-1:0] : w_used;
        w_new_entry.count = w_fit ? sat_inc(w_entry.count) : w_entry.count;
    end

    // Table write port: clearing pass or write-back
    always_comb begin
        if (w_clr_active) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_clr_addr;
            w_wr_data = '0;
        end else begin
            w_wr_en   = w_eval_go && w_counted;
            w_wr_addr = r_type[ADDR_W-1:0];
            w_wr_data = w_new_entry;
        end
    end

    // Per-type table, read on header acceptance
    always_ff @(posedge i_clk) begin
        if (w_wr_en) r_mem[w_wr_addr] <= w_wr_data;
        if (w_in_acc) r_rd_data <= r_mem[i_msg.msg_type[ADDR_W-1:0]];
    end

    // Bypass a write-back to the entry read in the same cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else if (w_in_acc) begin
            r_fwd_hit <= w_wr_en && (w_wr_addr == i_msg.msg_type[ADDR_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_fwd_data <= w_wr_data;
            r_type     <= i_msg.msg_type;
            r_time     <= i_msg.msg_time;
            r_len      <= i_msg.msg_len;
        end
    end

    // Advance the clearing pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (w_clr_active) begin
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
        end
    end

    // Window and total count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stamp     <= '0;
            r_epoch     <= '0;
            r_msg_count <= '0;
        end else if (w_eval_go) begin
            r_msg_count <= sat_inc(r_msg_count);
            if (w_counted && w_new_win) begin
                r_stamp <= r_time;
                r_epoch <= w_epoch_cur;
            end
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_budget   <= BUDGET_RESET;
            r_max_type <= MAX_TYPE_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.idx)
                REG_BUFFER_BUDGET: r_budget   <= i_cfg.data[BUDGET_W-1:0];
                REG_MAX_TYPE:      r_max_type <= i_cfg.data[TYPE_W-1:0];
                default:           r_budget   <= r_budget;
            endcase
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_eval_go) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_eval_go) begin
            r_out_acc     <= w_counted && w_fit;
            r_out_counted <= w_counted;
            r_out_total   <= w_counted ? w_new_entry.count : '0;
            r_out_all     <= sat_inc(r_msg_count);
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.accepted     = r_out_acc;
    assign o_res.type_counted = r_out_counted;
    assign o_res.type_total   = r_out_total;
    assign o_res.all_messages = r_out_all;

    // Checks
    `PTWBB_ASSERT_NXT(a_acc_to_eval, i_clk, i_rst_n, w_in_acc, r_state == S_EVAL)
    `PTWBB_ASSERT_NXT(a_clear_runs, i_clk, i_rst_n,
                      (r_state == S_CLEAR) && !w_clr_last, r_state == S_CLEAR)
    `PTWBB_ASSERT_IMP(a_uncounted_zero, i_clk, i_rst_n,
                      o_res.valid && !o_res.type_counted,
                      !o_res.accepted && (o_res.type_total == '0))
    `PTWBB_ASSERT_NXT(a_eval_result, i_clk, i_rst_n, w_eval_go, r_out_valid)

endmodule

/* bench/ptwbb_budget_checker.sv */
// Watch the header, result and register channels, predict each result and
// compare it field by field with what the core returns.
module ptwbb_budget_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    ptwbb_msg_if  msg_mon,
    ptwbb_res_if  res_mon,
    ptwbb_cfg_if  cfg_mon,
    output int    o_fail_count,
    output int    o_pending
);
    import ptwbb_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic             accepted;
        logic             type_counted;
        logic [CNT_W-1:0] type_total;
        logic [CNT_W-1:0] all_messages;
    } t_verdict;

    // Register copies
    logic [BUDGET_W-1:0] budget_q;
    logic [TYPE_W-1:0]   max_type_q;

    // Window and per-type state; absent table entries read as zero
    logic [TIME_W-1:0]   window_time;
    logic [EPOCH_W-1:0]  window_gen;
    logic [CNT_W-1:0]    seen_total;
    logic [EPOCH_W-1:0]  slot_gen [int];
    logic [USED_W-1:0]   slot_used [int];
    logic [CNT_W-1:0]    slot_accepts [int];

    t_verdict expected_verdicts [$];
    int       fail_count;
    int       reported;

    // Work out the result of one header and advance the window state
    function automatic t_verdict budget_predict(input logic [TYPE_W-1:0] kind,
                                                input logic [TIME_W-1:0] stamp,
                                                input logic [LEN_W-1:0]  len);
        t_verdict           v;
        int                 slot;
        logic [USED_W-1:0]  used;
        logic [33:0]        need;
        logic [CNT_W-1:0]   prior;
        v = '0;
        if (kind <= max_type_q && int'(kind) < TYPE_SLOTS) begin
            slot = int'(kind);
            v.type_counted = 1'b1;
            // Any new time stamp opens a fresh window for every type
            if (stamp != window_time) begin
                window_time = stamp;
                window_gen  = window_gen + 1'b1;
            end
            // Stale entry holds no bytes in this window
            if (!slot_gen.exists(slot) || slot_gen[slot] != window_gen) begin
                slot_gen[slot]  = window_gen;
                slot_used[slot] = '0;
            end
            used = slot_used[slot];
            need = 34'(used) + 34'(HEADER_BYTES) + 34'(len);
            if (need <= 34'(budget_q)) begin
                v.accepted      = 1'b1;
                slot_used[slot] = need[USED_W-1:0];
                prior = slot_accepts.exists(slot) ? slot_accepts[slot] : '0;
                slot_accepts[slot] = (&prior) ? prior : prior + 1'b1;
            end
            v.type_total = slot_accepts.exists(slot) ? slot_accepts[slot] : '0;
        end
        // Every header counts toward the total, stopping at all ones
        seen_total     = (&seen_total) ? seen_total : seen_total + 1'b1;
        v.all_messages = seen_total;
        return v;
    endfunction

    always @(posedge i_clk) begin
        t_verdict got;
        t_verdict want;
        if (!i_rst_n) begin
            budget_q    = BUDGET_RESET;
            max_type_q  = MAX_TYPE_RESET;
            window_time = '0;
            window_gen  = '0;
            seen_total  = '0;
            slot_gen.delete();
            slot_used.delete();
            slot_accepts.delete();
            expected_verdicts.delete();
            fail_count  = 0;
            reported    = 0;
        end else begin
            // Apply register writes
            if (cfg_mon.valid && cfg_mon.ready) begin
                case (cfg_mon.idx)
                    REG_BUFFER_BUDGET: budget_q = cfg_mon.data[BUDGET_W-1:0];
                    REG_MAX_TYPE:      max_type_q = cfg_mon.data[TYPE_W-1:0];
                    default: ;
                endcase
            end
            // Predict on each header beat
            if (msg_mon.valid && msg_mon.ready) begin
                expected_verdicts.push_back(budget_predict(msg_mon.msg_type,
                                                           msg_mon.msg_time,
                                                           msg_mon.msg_len));
            end
            // Compare each result beat with the oldest prediction
            if (res_mon.valid && res_mon.ready) begin
                got.accepted     = res_mon.accepted;
                got.type_counted = res_mon.type_counted;
                got.type_total   = res_mon.type_total;
                got.all_messages = res_mon.all_messages;
                if (expected_verdicts.size() == 0) begin
                    fail_count++;
                    if (reported < REPORT_LIMIT) begin
                        $display("unexpected result beat: acc=%0d cnt=%0d total=%0d all=%0d",
                                 got.accepted, got.type_counted, got.type_total,
                                 got.all_messages);
                    end
                    reported++;
                end else begin
                    want = expected_verdicts.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (reported < REPORT_LIMIT) begin
                            $display("result mismatch: expected acc=%0d cnt=%0d total=%0d all=%0d",
                                     want.accepted, want.type_counted, want.type_total,
                                     want.all_messages);
                            $display("                 actual   acc=%0d cnt=%0d total=%0d all=%0d",
                                     got.accepted, got.type_counted, got.type_total,
                                     got.all_messages);
                        end
                        reported++;
                    end
                end
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_verdicts.size();
    end

endmodule

/* bench/tb_per_type_window_byte_budget_core.sv */
// Drive headers, register writes and result back-pressure into the budget core.
module tb_per_type_window_byte_budget_core;
    import ptwbb_pkg::*;

    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 200;

    logic i_clk = 1'b0;
    logic i_rst_n;

    int  fail_count;
    int  pending;
    int  cycles = 0;
    bit  calm;
    int  stall_left = 0;

    logic [BUDGET_W-1:0] cur_budget;
    logic [TYPE_W-1:0]   cur_max_type;

    ptwbb_msg_if msg_bus ();
    ptwbb_res_if res_bus ();
    ptwbb_cfg_if cfg_bus ();

    per_type_window_byte_budget_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_msg   (msg_bus),
        .o_res   (res_bus),
        .i_cfg   (cfg_bus)
    );

    ptwbb_budget_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .msg_mon      (msg_bus),
        .res_mon      (res_bus),
        .cfg_mon      (cfg_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Bound the run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    // Stall the result channel at random
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            res_bus.ready = 1'b0;
            stall_left--;
        end else begin
            res_bus.ready = 1'b1;
            if (!calm && $urandom_range(0, 99) < 25)
                stall_left = pick_gap();
        end
    end

    // Send one header beat, with an optional idle gap ahead of it
    task automatic send_header(input logic [TYPE_W-1:0] kind,
                               input logic [TIME_W-1:0] stamp,
                               input logic [LEN_W-1:0]  len);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            msg_bus.valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        msg_bus.valid    = 1'b1;
        msg_bus.msg_type = kind;
        msg_bus.msg_time = stamp;
        msg_bus.msg_len  = len;
        @(posedge i_clk);
        while (!msg_bus.ready) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0]  idx,
                             input logic [REG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_bus.valid = 1'b1;
        cfg_bus.idx   = idx;
        cfg_bus.data  = data;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_bus.valid = 1'b0;
    endtask

    // Program both registers; the unused top bit of the budget write is noise
    task automatic set_limits(input logic [BUDGET_W-1:0] budget,
                              input logic [TYPE_W-1:0]   top_type);
        write_reg(REG_BUFFER_BUDGET, REG_DATA_W'({1'($urandom), budget}));
        write_reg(REG_MAX_TYPE, REG_DATA_W'(top_type));
        cur_budget   = budget;
        cur_max_type = top_type;
    endtask

    // Hold off until every predicted result has come back
    task automatic drain();
        @(negedge i_clk);
        msg_bus.valid = 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Runs of one type inside a window, with hot types at max_type, just above it, low and random
    task automatic run_random_phase(input int count);
        logic [TYPE_W-1:0] hot [4];
        logic [TYPE_W-1:0] kind;
        logic [TIME_W-1:0] stamp;
        logic [LEN_W-1:0]  len;
        int                r;
        hot[0] = cur_max_type;
        hot[1] = cur_max_type + 1'b1;
        hot[2] = TYPE_W'($urandom_range(0, 15));
        hot[3] = TYPE_W'($urandom_range(0, 2**TYPE_W - 1));
        kind   = hot[0];
        stamp  = $urandom;
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (r >= 85)
                kind = TYPE_W'($urandom_range(0, 2**TYPE_W - 1));
            else if (r >= 45)
                kind = hot[$urandom_range(0, 3)];
            r = $urandom_range(0, 99);
            if (r < 8)
                stamp = stamp + 1'b1;
            else if (r < 12)
                stamp = $urandom;
            r = $urandom_range(0, 99);
            if (r < 8)
                len = $urandom;
            else if (r < 16)
                len = LEN_W'($urandom_range(0, 65535));
            else if (r < 24)
                len = (cur_budget >= HEADER_BYTES) ? LEN_W'(cur_budget - HEADER_BYTES) : '0;
            else
                len = LEN_W'($urandom_range(0, cur_budget / 6 + 2));
            send_header(kind, stamp, len);
        end
    endtask

    initial begin
        i_rst_n          = 1'b0;
        calm             = 1'b0;
        cur_budget       = BUDGET_RESET;
        cur_max_type     = MAX_TYPE_RESET;
        msg_bus.valid    = 1'b0;
        msg_bus.msg_type = '0;
        msg_bus.msg_time = '0;
        msg_bus.msg_len  = '0;
        cfg_bus.valid    = 1'b0;
        cfg_bus.idx      = REG_BUFFER_BUDGET;
        cfg_bus.data     = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset limits: first window at time zero, exact fit, max_type edge
        send_header(0, 0, 0);
        send_header(0, 0, 2024);
        send_header(0, 0, 0);
        send_header(100000, 0, 0);
        send_header(100001, 0, 0);
        // Uncounted type must not open a window
        send_header(131071, 7, 0);
        send_header(0, 0, 0);
        send_header(0, 5, 0);
        // Oversize payload, then exact fit
        send_header(5, 5, 32'hFFFF_FFFF);
        send_header(5, 5, 2036);
        send_header(17'h15555, 32'hAAAA_AAAA, 32'h5555_5555);
        send_header(17'h0AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
        drain();

        // Zero budget and only type zero counted
        set_limits(16'd0, 17'd0);
        send_header(0, 1, 0);
        send_header(1, 1, 0);
        drain();

        // Widest settings
        set_limits(16'hFFFF, 17'h1FFFF);
        send_header(17'h1FFFF, 2, 65523);
        send_header(17'h1FFFF, 2, 0);
        send_header(17'h1FFFF, 3, 65524);
        send_header(3, 3, 65523);
        drain();

        // Random phases across several register settings
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: set_limits(16'hFFFF, 17'h1FFFF);
                1: set_limits(BUDGET_W'($urandom_range(12, 80)), TYPE_W'($urandom_range(0, 31)));
                2: set_limits(16'd0, 17'h1FFFF);
                4: set_limits(BUDGET_RESET, MAX_TYPE_RESET);
                5: set_limits(BUDGET_W'($urandom_range(100, 600)), 17'd0);
                7: set_limits(BUDGET_W'($urandom_range(24, 200)), 17'h1FFFF);
                default: set_limits(BUDGET_W'($urandom), TYPE_W'($urandom));
            endcase
            calm = (p % 3 == 2);
            run_random_phase(ITEMS_PER_PHASE);
            drain();
        end

        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* per_type_window_byte_budget_core.f */
+incdir+rtl
rtl/ptwbb_pkg.sv
rtl/ptwbb_msg_if.sv
rtl/ptwbb_res_if.sv
rtl/ptwbb_cfg_if.sv
rtl/per_type_window_byte_budget_core.sv
bench/ptwbb_budget_checker.sv
bench/tb_per_type_window_byte_budget_core.sv
